@@ hdl/dlmn_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlmn_pkg: shared types and constants
// Holds the transaction structs, register indexes and datapath widths of the
// depth linearize and min-normalize unit.
// ----------------------------------------------------------------------------
package dlmn_pkg;

	localparam int DEPTH_W = 24;
	localparam int FRAME_W = 17;
	localparam int INDEX_W = 16;
	localparam int PIX_W   = 8;
	localparam int PROD_W  = 2 * DEPTH_W;
	localparam int DIV_W   = PROD_W + 1;
	localparam int STEP_W  = 5;
	localparam int CFG_W   = 2;

	localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};
	localparam logic [PIX_W-1:0]   PIX_MAX   = {PIX_W{1'b1}};
	localparam logic [FRAME_W-1:0] FRAME_CAP = {FRAME_W{1'b1}};

	localparam logic [STEP_W-1:0] LIN_STEPS  = STEP_W'(DEPTH_W);
	localparam logic [STEP_W-1:0] NORM_STEPS = STEP_W'(PIX_W);

	localparam logic [CFG_W-1:0] REG_NEAR  = 2'd0;
	localparam logic [CFG_W-1:0] REG_FAR   = 2'd1;
	localparam logic [CFG_W-1:0] REG_SPAN  = 2'd2;
	localparam logic [CFG_W-1:0] REG_FRAME = 2'd3;

	localparam logic [DEPTH_W-1:0] NEAR_RST  = 24'd6554;
	localparam logic [DEPTH_W-1:0] FAR_RST   = 24'd655360;
	localparam logic [DEPTH_W-1:0] SPAN_RST  = 24'd11796;
	localparam logic [FRAME_W-1:0] FRAME_RST = 17'd65536;

	typedef struct packed {
		logic               op;
		logic [DEPTH_W-1:0] depth_code;
		logic [INDEX_W-1:0] pixel_index;
	} cmd_t;

	typedef struct packed {
		logic [PIX_W-1:0]   pixel_value;
		logic [DEPTH_W-1:0] frame_min;
		logic               last_pixel;
	} result_t;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
	} div_req_t;

endpackage

@@ hdl/dlmn_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlmn_div: shared radix-2 restoring divider
// Develops one quotient bit per cycle for a numerator below the divisor,
// giving floor(num * 2^steps / den).
// ----------------------------------------------------------------------------
module dlmn_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dlmn_pkg::div_req_t               req,
	input  logic [dlmn_pkg::DIV_W-1:0]       num,
	input  logic [dlmn_pkg::DIV_W-1:0]       den,
	output logic                             done,
	output logic [dlmn_pkg::DEPTH_W-1:0]     quot
);
	import dlmn_pkg::*;

	logic [DIV_W-1:0]   rem_q;
	logic [DIV_W-1:0]   den_q;
	logic [DEPTH_W-1:0] quot_q;
	logic [STEP_W-1:0]  cnt_q;
	logic               run_q;
	logic               done_q;
	logic [DIV_W:0]     rem_sh;
	logic               fits;
	logic [DIV_W:0]     rem_sub;

	assign rem_sh  = {rem_q, 1'b0};
	assign fits    = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= req.steps;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// payload: remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= num;
			den_q  <= den;
			quot_q <= '0;
		end else if (run_q) begin
			rem_q  <= fits ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
			quot_q <= {quot_q[DEPTH_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

@@ hdl/depth_linearize_min_normalize_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_linearize_min_normalize_unit: depth-buffer linearization and
// min-normalized readout
// Loads 24-bit depth codes in raster order as linear Q8.16 depths with a
// clip-range mark, tracks the frame minimum and returns 8-bit normalized
// pixels on read transactions.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; busy then stays
// high until the work is finished. A load transaction (op 0) runs the shared
// 24x24 multiplier for near*far and then code*|far-near|, builds the
// denominator, checks it and waits on the radix-2 divider for 24 quotient
// bits and the hand-over of the quotient, then stores. A load whose depth
// saturates skips the divider and goes from the check to the store.
// A read transaction (op 1) holds busy through memory read, difference,
// range check, 8 quotient bits and the hand-over of the quotient, and shows
// its result in the first cycle with busy low again. When the pixel is
// out of range, not valid or saturates at full scale, the read skips the
// divider and ends after the range check. Each read returns exactly one
// result, shown for a single cycle with done high; the receiver cannot
// stall it, so capture it on that cycle.
// Loads return nothing. Write configuration only while busy is low. The
// pixel store is not cleared at reset: read only pixels loaded since reset.
// ----------------------------------------------------------------------------
module depth_linearize_min_normalize_unit #(
	parameter int MAX_PIXELS = 65536
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  dlmn_pkg::cmd_t                  cmd,
	output logic                            done,
	output dlmn_pkg::result_t               result,
	input  logic                            cfg_we,
	input  logic [dlmn_pkg::CFG_W-1:0]      cfg_index,
	input  logic [dlmn_pkg::DEPTH_W-1:0]    cfg_data
);
	import dlmn_pkg::*;

	localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam logic [FRAME_W-1:0] MAX_LEN =
		(MAX_PIXELS > 131071) ? FRAME_CAP : FRAME_W'(MAX_PIXELS);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_LD_M1  = 4'd1;
	localparam logic [3:0] ST_LD_M2  = 4'd2;
	localparam logic [3:0] ST_LD_DEN = 4'd3;
	localparam logic [3:0] ST_LD_CHK = 4'd4;
	localparam logic [3:0] ST_LD_DIV = 4'd5;
	localparam logic [3:0] ST_LD_ST  = 4'd6;
	localparam logic [3:0] ST_RD_MEM = 4'd7;
	localparam logic [3:0] ST_RD_DIF = 4'd8;
	localparam logic [3:0] ST_RD_CHK = 4'd9;
	localparam logic [3:0] ST_RD_DIV = 4'd10;

	// configuration registers
	logic [DEPTH_W-1:0] near_q, far_q, span_q;
	logic [FRAME_W-1:0] frame_q;

	// control state
	logic [3:0]         state_q;
	logic [DEPTH_W-1:0] min_q;
	logic [FRAME_W-1:0] count_q;
	logic               done_q;

	// payload
	cmd_t               cmd_q;
	logic [PROD_W-1:0]  prod_q;
	logic [PROD_W-1:0]  num_q;
	logic [DIV_W-1:0]   den_q;
	logic [DEPTH_W-1:0] depth_q;
	logic [31:0]        scaled_q;
	logic [DEPTH_W:0]   rd_q;
	result_t            result_q;

	logic [DEPTH_W:0]   mem [MAX_PIXELS];

	logic [FRAME_W-1:0] frame_len;
	logic               far_ge_near;
	logic [DEPTH_W-1:0] plane_gap;
	logic [DEPTH_W-1:0] mul_a, mul_b;
	logic [DIV_W-1:0]   far_sh;
	logic               in_range;
	logic               is_last;
	logic [DEPTH_W-1:0] span_eff;
	logic [31:0]        span_sh;
	logic [DEPTH_W-1:0] diff;
	logic               d_valid;
	logic               new_frame;
	logic [DEPTH_W-1:0] min_base;
	logic [AW-1:0]      wr_addr;
	logic               mem_we;
	div_req_t           div_req;
	logic [DIV_W-1:0]   div_num, div_den;
	logic               div_done;
	logic [DEPTH_W-1:0] div_quot;

	assign frame_len = (frame_q == '0) ? FRAME_W'(1) :
		(frame_q > MAX_LEN) ? MAX_LEN : frame_q;

	// far - near magnitude; the sign picks add or subtract in the denominator
	assign far_ge_near = far_q >= near_q;
	assign plane_gap   = far_ge_near ? far_q - near_q : near_q - far_q;
	assign far_sh      = DIV_W'({far_q, {DEPTH_W{1'b0}}});

	assign in_range = FRAME_W'(cmd_q.pixel_index) < frame_len;
	assign is_last  = in_range && (FRAME_W'(cmd_q.pixel_index) == frame_len - 1'b1);
	assign span_eff = (span_q == '0) ? DEPTH_W'(1) : span_q;
	assign span_sh  = {span_eff, 8'b0};
	assign diff     = (rd_q[DEPTH_W-1:0] > min_q) ? rd_q[DEPTH_W-1:0] - min_q : '0;

	assign d_valid   = (near_q < depth_q) && (depth_q < far_q);
	assign new_frame = (count_q == '0) || (count_q >= frame_len);
	assign min_base  = new_frame ? far_q : min_q;
	assign wr_addr   = new_frame ? '0 : AW'(count_q);
	assign mem_we    = state_q == ST_LD_ST;

	// shared multiplier: near*far first, then code*|far-near|
	always_comb begin
		if (state_q == ST_LD_M1) begin
			mul_a = near_q;
			mul_b = far_q;
		end else begin
			mul_a = cmd_q.depth_code;
			mul_b = plane_gap;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// divider operands and launch
	always_comb begin
		div_req.start = 1'b0;
		div_req.steps = LIN_STEPS;
		div_num       = DIV_W'(num_q);
		div_den       = den_q;
		if (state_q == ST_LD_CHK) begin
			div_req.start = (den_q != '0) && (DIV_W'(num_q) < den_q);
		end else if (state_q == ST_RD_CHK) begin
			div_req.start = in_range && rd_q[DEPTH_W] && (scaled_q < span_sh);
			div_req.steps = NORM_STEPS;
			div_num       = DIV_W'(scaled_q);
			div_den       = DIV_W'(span_sh);
		end
	end

	dlmn_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q  <= NEAR_RST;
			far_q   <= FAR_RST;
			span_q  <= SPAN_RST;
			frame_q <= FRAME_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NEAR:  near_q  <= cfg_data;
				REG_FAR:   far_q   <= cfg_data;
				REG_SPAN:  span_q  <= cfg_data;
				REG_FRAME: frame_q <= FRAME_W'(cfg_data);
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			min_q   <= FAR_RST;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= cmd.op ? ST_RD_MEM : ST_LD_M1;
					end
				end
				ST_LD_M1:  state_q <= ST_LD_M2;
				ST_LD_M2:  state_q <= ST_LD_DEN;
				ST_LD_DEN: state_q <= ST_LD_CHK;
				ST_LD_CHK: state_q <= div_req.start ? ST_LD_DIV : ST_LD_ST;
				ST_LD_DIV: begin
					if (div_done) begin
						state_q <= ST_LD_ST;
					end
				end
				ST_LD_ST: begin
					// restart the frame when the count wrapped, then store
					count_q <= (new_frame ? '0 : count_q) + 1'b1;
					min_q   <= (d_valid && depth_q < min_base) ? depth_q : min_base;
					state_q <= ST_IDLE;
				end
				ST_RD_MEM: state_q <= ST_RD_DIF;
				ST_RD_DIF: state_q <= ST_RD_CHK;
				ST_RD_CHK: begin
					if (div_req.start) begin
						state_q <= ST_RD_DIV;
					end else begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_RD_DIV: begin
					if (div_done) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cmd_q <= cmd;
		end
		if (state_q == ST_LD_M2) begin
			num_q <= prod_q;
		end
		if (state_q == ST_LD_DEN) begin
			den_q <= far_ge_near ? far_sh - DIV_W'(prod_q) : far_sh + DIV_W'(prod_q);
		end
		if (state_q == ST_LD_CHK) begin
			depth_q <= DEPTH_MAX;
		end else if (state_q == ST_LD_DIV && div_done) begin
			depth_q <= div_quot;
		end
		// diff * 255 as a shift and subtract
		if (state_q == ST_RD_DIF) begin
			scaled_q <= {diff, 8'b0} - 32'(diff);
		end
		if (state_q == ST_RD_CHK && !div_req.start) begin
			result_q.pixel_value <= (in_range && rd_q[DEPTH_W]) ? PIX_MAX : '0;
			result_q.frame_min   <= min_q;
			result_q.last_pixel  <= is_last;
		end else if (state_q == ST_RD_DIV && div_done) begin
			result_q.pixel_value <= div_quot[PIX_W-1:0];
			result_q.frame_min   <= min_q;
			result_q.last_pixel  <= is_last;
		end
	end

	// pixel store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= {d_valid, depth_q};
		end
		rd_q <= mem[AW'(cmd_q.pixel_index)];
	end

	assign busy   = state_q != ST_IDLE;
	assign done   = done_q;
	assign result = result_q;

	a_done_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == ST_RD_CHK || $past(state_q) == ST_RD_DIV)
		else $error("result strobe without a read in progress");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_LD_DIV || state_q == ST_RD_DIV)
		else $error("divider finished outside a wait state");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_LEN)
		else $error("load count beyond store depth");

endmodule

@@ test/tb_depth_linearize_min_normalize_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_depth_linearize_min_normalize_unit: self-checking bench for the depth
// linearize and min-normalize unit
// Drives load and read transactions through the start/busy handshake and
// programs the clip, span and frame registers between phases. An in-bench
// predictor keeps its own pixel store, running minimum and fill count,
// computes every expected readout, and the checker compares each done strobe
// field by field. A directed opening covers field extremes and odd register
// values; random frames with random content make up the bulk of the run.
// ----------------------------------------------------------------------------
module tb_depth_linearize_min_normalize_unit;
	import dlmn_pkg::*;

	localparam int   MAX_PIXELS     = 65536;
	localparam int   MAX_GAP        = 17;
	localparam int   SETTLE_CYCLES  = 48;
	localparam int   WATCHDOG_LIMIT = 2000;
	localparam int   RANDOM_ITEMS   = 500;
	localparam logic OP_LOAD        = 1'b0;
	localparam logic OP_READ        = 1'b1;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	cmd_t               cmd;
	logic               done;
	result_t            result;
	logic               cfg_we;
	logic [CFG_W-1:0]   cfg_index;
	logic [DEPTH_W-1:0] cfg_data;

	// Register mirrors and predictor state
	logic [DEPTH_W-1:0] near_q;
	logic [DEPTH_W-1:0] far_q;
	logic [DEPTH_W-1:0] span_q;
	logic [FRAME_W-1:0] frame_q;
	logic [DEPTH_W-1:0] min_q;
	int                 fill_count;
	logic [DEPTH_W:0]   pixel_mem [MAX_PIXELS];
	bit                 pixel_seen [MAX_PIXELS];

	result_t pixel_expect [$];
	int      errors;
	int      items_sent;
	int      stall_cycles;
	bit      no_gaps;

	depth_linearize_min_normalize_unit #(
		.MAX_PIXELS(MAX_PIXELS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// Zero frame length counts as one pixel; anything past the store is capped.
	function automatic int frame_length();
		if (frame_q == '0) return 1;
		if (int'(frame_q) > MAX_PIXELS) return MAX_PIXELS;
		return int'(frame_q);
	endfunction

	// near*far / (far - z*(far-near)) with z = code / 2^24, scaled by 2^24 so the
	// division is exact; the signed difference is kept by picking add or subtract.
	function automatic logic [DEPTH_W-1:0] linear_depth(input logic [DEPTH_W-1:0] code);
		logic [63:0] n64;
		logic [63:0] f64;
		logic [63:0] c64;
		logic [63:0] num;
		logic [63:0] den;
		logic [87:0] quot;
		n64 = 64'(near_q);
		f64 = 64'(far_q);
		c64 = 64'(code);
		num = n64 * f64;
		if (f64 >= n64) begin
			den = (f64 << DEPTH_W) - c64 * (f64 - n64);
		end else begin
			den = (f64 << DEPTH_W) + c64 * (n64 - f64);
		end
		// Saturate on a zero denominator or a quotient past 24 bits
		if (den == 64'd0 || num >= den) return DEPTH_MAX;
		quot = {num[47:0], 24'd0} / {24'd0, den};
		return quot[DEPTH_W-1:0];
	endfunction

	// Advance the store and the running minimum for one accepted load.
	task automatic track_load(input logic [DEPTH_W-1:0] code);
		logic [DEPTH_W-1:0] d;
		logic               valid;
		d     = linear_depth(code);
		valid = (near_q < d) && (d < far_q);
		// A load at the start or past the end of a frame opens a new frame
		if (fill_count == 0 || fill_count >= frame_length()) begin
			fill_count = 0;
			min_q      = far_q;
		end
		pixel_mem[fill_count]  = {valid, d};
		pixel_seen[fill_count] = 1'b1;
		if (valid && d < min_q) min_q = d;
		fill_count++;
	endtask

	function automatic result_t predict_readout(input logic [INDEX_W-1:0] idx);
		result_t          r;
		logic [DEPTH_W:0] entry;
		logic [63:0]      d;
		logic [63:0]      diff;
		logic [63:0]      span;
		logic [63:0]      scaled;
		int               len;
		len           = frame_length();
		r.pixel_value = '0;
		r.frame_min   = min_q;
		r.last_pixel  = 1'b0;
		if (int'(idx) < len) begin
			entry        = pixel_mem[idx];
			r.last_pixel = (int'(idx) == len - 1);
			if (entry[DEPTH_W]) begin
				d    = 64'(entry[DEPTH_W-1:0]);
				span = (span_q == '0) ? 64'd1 : 64'(span_q);
				// Stale depths below the current minimum clamp to zero
				diff   = (d > 64'(min_q)) ? d - 64'(min_q) : 64'd0;
				scaled = diff * 64'(PIX_MAX) / span;
				r.pixel_value = (scaled > 64'(PIX_MAX)) ? PIX_MAX : scaled[PIX_W-1:0];
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------

	// Write one register at a falling edge; the mirror masks to register width.
	task automatic set_reg(input logic [CFG_W-1:0] index, input logic [DEPTH_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (index)
			REG_NEAR:  near_q  = value;
			REG_FAR:   far_q   = value;
			REG_SPAN:  span_q  = value;
			REG_FRAME: frame_q = value[FRAME_W-1:0];
			default: ;
		endcase
	endtask

	// Hold start high with the transaction until busy is seen low at a rising
	// edge, then predict. Start is left high so back-to-back items never drop it.
	task automatic send_cmd(input cmd_t item);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		cmd   <= item;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (item.op == OP_READ) begin
			pixel_expect.push_back(predict_readout(item.pixel_index));
		end else begin
			track_load(item.depth_code);
		end
		items_sent++;
	endtask

	// Unused fields carry random bits so every input bit toggles.
	task automatic load_code(input logic [DEPTH_W-1:0] code);
		cmd_t item;
		item.op          = OP_LOAD;
		item.depth_code  = code;
		item.pixel_index = INDEX_W'($urandom);
		send_cmd(item);
	endtask

	task automatic read_pixel(input logic [INDEX_W-1:0] idx);
		cmd_t item;
		item.op          = OP_READ;
		item.depth_code  = DEPTH_W'($urandom);
		item.pixel_index = idx;
		send_cmd(item);
	endtask

	// Drop start, wait out every pending readout, then let a trailing load finish.
	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (pixel_expect.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Pick a read target: mostly loaded pixels in the frame, some at the last
	// pixel, some beyond the frame. Never touch a store entry that was not loaded.
	function automatic logic [INDEX_W-1:0] pick_index();
		int len;
		int sel;
		int idx;
		len = frame_length();
		sel = $urandom_range(0, 9);
		if (sel < 7) begin
			idx = $urandom_range(0, len - 1);
		end else if (sel < 8) begin
			idx = len - 1;
		end else if (len < MAX_PIXELS) begin
			return INDEX_W'($urandom_range(len, MAX_PIXELS - 1));
		end else begin
			idx = $urandom_range(0, len - 1);
		end
		if (!pixel_seen[idx]) begin
			idx = (len < MAX_PIXELS) ? $urandom_range(len, MAX_PIXELS - 1) : 0;
		end
		return INDEX_W'(idx);
	endfunction

	function automatic logic [DEPTH_W-1:0] random_code();
		if ($urandom_range(0, 7) == 0) begin
			return $urandom_range(0, 1) ? DEPTH_MAX : '0;
		end
		return DEPTH_W'($urandom);
	endfunction

	task automatic randomize_registers();
		int near_v;
		int far_v;
		int spread;
		int span_v;
		int frame_v;
		case ($urandom_range(0, 7))
			0: begin
				near_v = 1;
				far_v  = DEPTH_MAX;
			end
			1: begin
				// far below near
				near_v = DEPTH_MAX;
				far_v  = $urandom_range(0, DEPTH_MAX);
			end
			2: begin
				near_v = 0;
				far_v  = $urandom_range(1, DEPTH_MAX);
			end
			default: begin
				near_v = $urandom_range(1, 1 << 20);
				far_v  = $urandom_range(near_v + 1, DEPTH_MAX);
			end
		endcase
		spread = (far_v > near_v) ? far_v - near_v : near_v - far_v;
		case ($urandom_range(0, 9))
			0:       span_v = 0;
			1:       span_v = 1;
			2:       span_v = DEPTH_MAX;
			default: span_v = $urandom_range(1, spread + 1);
		endcase
		// Mostly short frames; a few full-size and out-of-range lengths
		case ($urandom_range(0, 19))
			0:       frame_v = 0;
			1:       frame_v = MAX_PIXELS;
			2:       frame_v = DEPTH_MAX;
			3, 4:    frame_v = $urandom_range(49, 300);
			default: frame_v = $urandom_range(1, 48);
		endcase
		set_reg(REG_NEAR, DEPTH_W'(near_v));
		set_reg(REG_FAR, DEPTH_W'(far_v));
		set_reg(REG_SPAN, DEPTH_W'(span_v));
		set_reg(REG_FRAME, DEPTH_W'(frame_v));
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Reset registers: depth at the near plane, just under the far plane, mid
	// codes, then read every loaded pixel.
	task automatic test_reset_config();
		int i;
		load_code('0);
		load_code(DEPTH_MAX);
		load_code(24'h800000);
		load_code(24'hF00000);
		load_code(24'h000001);
		for (i = 0; i < 5; i++) read_pixel(INDEX_W'(i));
	endtask

	// Frame of five: last pixel flag, reads past the frame, then a new frame
	// that resets the minimum while older pixels stay readable.
	task automatic test_frame_edges();
		drain_results();
		set_reg(REG_FRAME, DEPTH_W'(5));
		read_pixel(INDEX_W'(4));
		read_pixel(INDEX_W'(5));
		read_pixel({INDEX_W{1'b1}});
		load_code(24'h123456);
		read_pixel(INDEX_W'(1));
		read_pixel(INDEX_W'(0));
	endtask

	// Far below near, zero span, zero frame length, a zero denominator and a
	// frame length written with bits above the register width.
	task automatic test_odd_registers();
		drain_results();
		set_reg(REG_NEAR, FAR_RST);
		set_reg(REG_FAR, NEAR_RST);
		set_reg(REG_SPAN, '0);
		set_reg(REG_FRAME, '0);
		load_code(DEPTH_MAX);
		read_pixel(INDEX_W'(0));
		read_pixel(INDEX_W'(1));
		drain_results();
		set_reg(REG_NEAR, DEPTH_W'(100));
		set_reg(REG_FAR, '0);
		set_reg(REG_SPAN, DEPTH_MAX);
		set_reg(REG_FRAME, DEPTH_MAX);
		load_code('0);
		read_pixel(INDEX_W'(1));
	endtask

	// Random phases: new registers, a frame of loads with a few stray reads,
	// then a burst of reads with stray loads and occasional full drains.
	task automatic test_random_frames();
		int target;
		int len;
		int n_loads;
		int n_reads;
		int i;
		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			drain_results();
			randomize_registers();
			no_gaps = ($urandom_range(0, 3) == 0);
			len     = frame_length();
			n_loads = ((len > 60) ? 60 : len) + $urandom_range(0, 3);
			for (i = 0; i < n_loads; i++) begin
				if ($urandom_range(0, 9) == 0) read_pixel(pick_index());
				load_code(random_code());
			end
			n_reads = $urandom_range(1, 24);
			for (i = 0; i < n_reads; i++) begin
				read_pixel(pick_index());
				if ($urandom_range(0, 11) == 0) drain_results();
				if ($urandom_range(0, 15) == 0) load_code(random_code());
			end
		end
		no_gaps = 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Checker: compare every strobed readout against the oldest prediction.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done === 1'b1) begin
			if (pixel_expect.size() == 0) begin
				errors++;
				$display("%0t: unexpected readout, expected none, got value %0d min %0d last %0b",
					$time, result.pixel_value, result.frame_min, result.last_pixel);
			end else begin
				want = pixel_expect.pop_front();
				if (result.pixel_value !== want.pixel_value) begin
					errors++;
					$display("%0t: pixel_value expected %0d got %0d",
						$time, want.pixel_value, result.pixel_value);
				end
				if (result.frame_min !== want.frame_min) begin
					errors++;
					$display("%0t: frame_min expected %0d got %0d",
						$time, want.frame_min, result.frame_min);
				end
				if (result.last_pixel !== want.last_pixel) begin
					errors++;
					$display("%0t: last_pixel expected %0b got %0b",
						$time, want.last_pixel, result.last_pixel);
				end
			end
		end
	end

	// Watchdog: any accepted transaction, readout or register write resets it.
	always @(posedge clk) begin
		if ((start && !busy) || done === 1'b1 || cfg_we) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
		end
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL depth_linearize_min_normalize_unit");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		cmd          = '0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		near_q       = NEAR_RST;
		far_q        = FAR_RST;
		span_q       = SPAN_RST;
		frame_q      = FRAME_RST;
		min_q        = FAR_RST;
		fill_count   = 0;
		errors       = 0;
		items_sent   = 0;
		stall_cycles = 0;
		no_gaps      = 1'b0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_config();
		test_frame_edges();
		test_odd_registers();
		test_random_frames();
		drain_results();

		if (errors == 0) begin
			$display("PASS depth_linearize_min_normalize_unit");
		end else begin
			$display("FAIL depth_linearize_min_normalize_unit");
		end
		$finish;
	end

endmodule
